FILE: hdl/wamin_pkg.sv
// Package for the windowed average / running minimum block.
// Holds widths, command codes, the queue item type and the config write type.
// No dependencies.
package wamin_pkg;

  // Sizes
  localparam int RING_DEPTH  = 12;
  localparam int MAX_SAMPLES = 4095;
  localparam int PRESSURE_W  = 16;
  localparam int CYL_W       = 4;
  localparam int CNT_W       = 12;
  localparam int SUM_W       = CNT_W + PRESSURE_W;
  localparam int CMD_W       = 2;
  localparam int LEN_W       = $clog2(RING_DEPTH + 1);
  localparam int RIDX_W      = $clog2(RING_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = PRESSURE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = {PRESSURE_W{1'b1}};

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_BUFFER_LENGTH = 1'b0;  // word address of buffer_length

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

  // Decoded operation carried through the queue
  typedef enum logic [1:0] {
    OP_START,
    OP_SAMPLE,
    OP_STOP
  } wamin_op_t;

  typedef struct packed {
    wamin_op_t             op;
    logic [CYL_W-1:0]      cylinder;
    logic [PRESSURE_W-1:0] pressure;
  } wamin_item_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] value;
  } wamin_cfg_wr_t;

endpackage

FILE: hdl/wamin_if.sv
// Channel interfaces for the windowed average block: input and result beats.
// Depends on wamin_pkg for field widths.
interface wamin_in_if;
  logic                            valid;
  logic                            ready;
  logic [wamin_pkg::CMD_W-1:0]     cmd;
  logic [wamin_pkg::CYL_W-1:0]     cylinder;
  logic [wamin_pkg::PRESSURE_W-1:0] sample_pressure;

  modport source (output valid, cmd, cylinder, sample_pressure, input ready);
  modport sink   (input valid, cmd, cylinder, sample_pressure, output ready);
endinterface

interface wamin_out_if;
  logic                             valid;
  logic                             ready;
  logic [wamin_pkg::PRESSURE_W-1:0] average_pressure;
  logic [wamin_pkg::PRESSURE_W-1:0] min_pressure;
  logic [wamin_pkg::CYL_W-1:0]      cylinder_out;
  logic [wamin_pkg::CNT_W-1:0]      sample_count;
  logic                             status;

  modport source (output valid, average_pressure, min_pressure, cylinder_out,
                  sample_count, status, input ready);
  modport sink   (input valid, average_pressure, min_pressure, cylinder_out,
                  sample_count, status, output ready);
endinterface

FILE: hdl/windowed_average_running_min.sv
// Windowed average with running minimum. A start beat opens a window for a
// cylinder, sample beats accumulate pressure, and a stop beat yields one result
// beat with the truncated average, the minimum over the last buffer_length
// averages, the cylinder and the sample count (status 1 when no samples came).
// The back end takes start and sample beats straight from its idle state; beats with an
// unknown command code are dropped at decode and never reach it. A stop with
// samples is popped, runs through the bit-serial divider, writes the ring,
// scans buffer_length entries for the minimum over the single ring read port
// and loads the output register; a stop on an empty window goes straight to
// loading the output register. A decode stage and a two-entry
// queue let the input side keep taking beats while a stop is worked off or a
// result waits. buffer_length sits at byte address 0 of the APB-style port.
module windowed_average_running_min (
  input  logic                               clk,
  input  logic                               rst_n,
  wamin_in_if.sink                           in_ch,
  wamin_out_if.source                        out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wamin_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wamin_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wamin_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready
);

  logic                              push, push_ready;
  wamin_pkg::wamin_item_t            push_item;
  logic                              q_valid, q_pop;
  wamin_pkg::wamin_item_t            q_item;
  wamin_pkg::wamin_cfg_wr_t          cfg_wr;
  logic [wamin_pkg::LEN_W-1:0]       buffer_length;
  logic                              sel_len;

  // Register decode on the word address
  assign pready       = 1'b1;
  assign sel_len      = paddr[2] == wamin_pkg::REG_BUFFER_LENGTH;
  assign cfg_wr.en    = psel && penable && pwrite && pready && sel_len;
  assign cfg_wr.value = pwdata[wamin_pkg::LEN_W-1:0];
  assign prdata       = sel_len ? wamin_pkg::CFG_DATA_W'(buffer_length) : '0;

  wamin_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  wamin_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  wamin_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .cfg_wr        (cfg_wr),
    .buffer_length (buffer_length),
    .out_ch        (out_ch)
  );

endmodule

FILE: hdl/wamin_front.sv
// Front end: accepts input beats, decodes the command and drops unknown codes.
// Depends on wamin_pkg and wamin_in_if.
module wamin_front (
  input  logic                   clk,
  input  logic                   rst_n,
  wamin_in_if.sink               in_ch,
  output logic                   push,
  output wamin_pkg::wamin_item_t push_item,
  input  logic                   push_ready
);

  logic                   stage_v_r, stage_v_nxt;
  wamin_pkg::wamin_item_t stage_item_r, stage_item_nxt;
  logic                   accept;
  logic                   known;
  wamin_pkg::wamin_op_t   op;

  assign in_ch.ready = !stage_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = stage_v_r;
  assign push_item   = stage_item_r;

  // Decode the command code
  always_comb begin
    known = 1'b1;
    op    = wamin_pkg::OP_START;
    unique case (in_ch.cmd)
      wamin_pkg::CMD_START:  op = wamin_pkg::OP_START;
      wamin_pkg::CMD_SAMPLE: op = wamin_pkg::OP_SAMPLE;
      wamin_pkg::CMD_STOP:   op = wamin_pkg::OP_STOP;
      default:               known = 1'b0;
    endcase
  end

  // Hold one decoded beat until the queue takes it
  always_comb begin
    stage_v_nxt    = stage_v_r && !push_ready;
    stage_item_nxt = stage_item_r;
    if (accept) begin
      stage_v_nxt             = known;
      stage_item_nxt.op       = op;
      stage_item_nxt.cylinder = in_ch.cylinder;
      stage_item_nxt.pressure = in_ch.sample_pressure;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    stage_item_r <= stage_item_nxt;
  end

endmodule

FILE: hdl/wamin_queue.sv
// Short queue between the front end and the back end.
// Depends on wamin_pkg.
module wamin_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  wamin_pkg::wamin_item_t push_item,
  output logic                   push_ready,
  output logic                   pop_valid,
  output wamin_pkg::wamin_item_t pop_item,
  input  logic                   pop
);

  wamin_pkg::wamin_item_t             entry_r [wamin_pkg::QUEUE_DEPTH];
  logic [wamin_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [wamin_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [wamin_pkg::QPTR_W:0]         fill_r, fill_nxt;
  logic                               do_push, do_pop;

  assign push_ready = fill_r != (wamin_pkg::QPTR_W+1)'(wamin_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == wamin_pkg::QPTR_W'(wamin_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == wamin_pkg::QPTR_W'(wamin_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/wamin_back.sv
// Back end: window accumulation, serial divider, average ring and minimum scan.
// Depends on wamin_pkg and wamin_out_if.
module wamin_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  wamin_pkg::wamin_item_t   q_item,
  output logic                     q_pop,
  input  wamin_pkg::wamin_cfg_wr_t cfg_wr,
  output logic [wamin_pkg::LEN_W-1:0] buffer_length,
  wamin_out_if.source              out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RING,
    ST_SCAN,
    ST_EMIT
  } state_t;

  localparam int PW = wamin_pkg::PRESSURE_W;
  localparam int CW = wamin_pkg::CNT_W;
  localparam int SW = wamin_pkg::SUM_W;
  localparam int LW = wamin_pkg::LEN_W;
  localparam int RW = wamin_pkg::RIDX_W;
  localparam int DW = wamin_pkg::DIV_CNT_W;

  state_t                 state_r, state_nxt;
  logic                   open_r, open_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [wamin_pkg::CYL_W-1:0] cyl_r, cyl_nxt;
  logic                   empty_r, empty_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [PW-1:0]          quo_r, quo_nxt;
  logic [DW-1:0]          step_r, step_nxt;
  logic [RW-1:0]          ridx_r, ridx_nxt;
  logic [RW-1:0]          scan_r, scan_nxt;
  logic [PW-1:0]          min_r, min_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [PW-1:0]          out_avg_r, out_avg_nxt;
  logic [PW-1:0]          out_min_r, out_min_nxt;
  logic [wamin_pkg::CYL_W-1:0] out_cyl_r, out_cyl_nxt;
  logic [CW-1:0]          out_cnt_r, out_cnt_nxt;
  logic                   out_st_r, out_st_nxt;

  logic [PW-1:0]          ring_r [wamin_pkg::RING_DEPTH];

  logic [CW:0]            trial;
  logic [CW:0]            diff;
  logic                   fits;
  logic [LW-1:0]          ridx_inc;
  logic [LW-1:0]          len_clamp;
  logic [PW-1:0]          ring_rd;
  logic                   out_free;

  assign buffer_length = len_r;

  assign out_ch.valid            = out_v_r;
  assign out_ch.average_pressure = out_avg_r;
  assign out_ch.min_pressure     = out_min_r;
  assign out_ch.cylinder_out     = out_cyl_r;
  assign out_ch.sample_count     = out_cnt_r;
  assign out_ch.status           = out_st_r;

  // One restoring division step: shift in the next dividend bit, try subtract
  assign trial = {rem_r, quo_r[PW-1]};
  assign fits  = trial >= {1'b0, cnt_r};
  assign diff  = trial - {1'b0, cnt_r};

  assign ridx_inc = LW'(ridx_r) + 1'b1;
  assign ring_rd  = ring_r[scan_r];
  assign out_free = !out_v_r || out_ch.ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // Clamp a written ring length to the supported range
  always_comb begin
    len_clamp = cfg_wr.value;
    if (cfg_wr.value == '0) begin
      len_clamp = LW'(1);
    end else if (cfg_wr.value > LW'(wamin_pkg::RING_DEPTH)) begin
      len_clamp = LW'(wamin_pkg::RING_DEPTH);
    end
  end

  // Sequencer for window commands and the stop report
  always_comb begin
    state_nxt   = state_r;
    open_nxt    = open_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    cyl_nxt     = cyl_r;
    empty_nxt   = empty_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    ridx_nxt    = ridx_r;
    scan_nxt    = scan_r;
    min_nxt     = min_r;
    len_nxt     = len_r;
    out_v_nxt   = out_v_r && !out_ch.ready;
    out_avg_nxt = out_avg_r;
    out_min_nxt = out_min_r;
    out_cyl_nxt = out_cyl_r;
    out_cnt_nxt = out_cnt_r;
    out_st_nxt  = out_st_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            wamin_pkg::OP_START: begin
              sum_nxt  = '0;
              cnt_nxt  = '0;
              open_nxt = 1'b1;
              cyl_nxt  = q_item.cylinder;
            end
            wamin_pkg::OP_SAMPLE: begin
              // Drop samples while closed or once the count saturates
              if (open_r && cnt_r < CW'(wamin_pkg::MAX_SAMPLES)) begin
                cnt_nxt = cnt_r + 1'b1;
                sum_nxt = sum_r + SW'(q_item.pressure);
              end
            end
            wamin_pkg::OP_STOP: begin
              open_nxt = 1'b0;
              if (cnt_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_EMIT;
              end else begin
                // Quotient fits 16 bits, so the top bits seed the remainder
                empty_nxt = 1'b0;
                rem_nxt   = sum_r[SW-1 -: CW];
                quo_nxt   = sum_r[PW-1:0];
                step_nxt  = '0;
                state_nxt = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = fits ? diff[CW-1:0] : trial[CW-1:0];
        quo_nxt  = {quo_r[PW-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == DW'(wamin_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        // Ring write happens in the storage block; advance the index here
        ridx_nxt  = (ridx_inc >= len_r) ? '0 : ridx_inc[RW-1:0];
        scan_nxt  = '0;
        min_nxt   = wamin_pkg::PRESSURE_MAX;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        min_nxt  = (ring_rd < min_r) ? ring_rd : min_r;
        scan_nxt = scan_r + 1'b1;
        if (LW'(scan_r) == len_r - 1'b1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_avg_nxt = empty_r ? '0 : quo_r;
          out_min_nxt = empty_r ? '0 : min_r;
          out_cyl_nxt = cyl_r;
          out_cnt_nxt = empty_r ? '0 : cnt_r;
          out_st_nxt  = empty_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Length write restarts the ring
    if (cfg_wr.en) begin
      len_nxt  = len_clamp;
      ridx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      open_r  <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
      cyl_r   <= '0;
      ridx_r  <= '0;
      len_r   <= LW'(1);
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      cyl_r   <= cyl_nxt;
      ridx_r  <= ridx_nxt;
      len_r   <= len_nxt;
      out_v_r <= out_v_nxt;
    end
    empty_r   <= empty_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    scan_r    <= scan_nxt;
    min_r     <= min_nxt;
    out_avg_r <= out_avg_nxt;
    out_min_r <= out_min_nxt;
    out_cyl_r <= out_cyl_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  // Average ring: reset, and length writes below len_clamp, fill with max value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wamin_pkg::RING_DEPTH; i++) begin
        ring_r[i] <= wamin_pkg::PRESSURE_MAX;
      end
    end else if (cfg_wr.en) begin
      for (int i = 0; i < wamin_pkg::RING_DEPTH; i++) begin
        if (LW'(i) < len_clamp) begin
          ring_r[i] <= wamin_pkg::PRESSURE_MAX;
        end
      end
    end else if (state_r == ST_RING) begin
      ring_r[ridx_r] <= quo_r;
    end
  end

endmodule
